// ===== hw/rtl/trapezoid_membership_assert.svh =====
`ifndef TRAPEZOID_MEMBERSHIP_ASSERT_SVH
`define TRAPEZOID_MEMBERSHIP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tm_pkg.sv =====
package tm_pkg;

   localparam int OPER_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_ZERO  = 2'd0;
   localparam logic [1:0] KIND_ONE   = 2'd1;
   localparam logic [1:0] KIND_RATIO = 2'd2;

   typedef logic [1:0] kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [OPER_W-1:0] num;
      logic [OPER_W-1:0] den;
   } grade_item_type;

endpackage

// ===== hw/rtl/tm_front.sv =====
module tm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [31:0]     sample_value,
   input  logic signed [31:0]     rise_start,
   input  logic signed [31:0]     rise_end,
   input  logic signed [31:0]     fall_start,
   input  logic signed [31:0]     fall_end,
   output logic                   push_valid,
   input  logic                   queue_full,
   output tm_pkg::grade_item_type push_item
);
   import tm_pkg::*;

   logic signed [31:0] b1, b2, b3;
   logic signed [32:0] num_wide, den_wide;
   logic signed [31:0] num_hi, num_lo, den_hi, den_lo;
   grade_item_type     item;
   logic               in_fire, push_fire;
   logic               front_vld_ff, front_vld_in;
   grade_item_type     front_item_ff;

   // force breakpoints into order
   always_comb begin
      b1 = (rise_end < rise_start) ? rise_start : rise_end;
      b2 = (fall_start < b1) ? b1 : fall_start;
      b3 = (fall_end < b2) ? b2 : fall_end;
   end

   always_comb begin
      item.kind = KIND_ZERO;
      num_hi = sample_value;
      num_lo = rise_start;
      den_hi = b1;
      den_lo = rise_start;
      if (sample_value < rise_start) begin
         item.kind = KIND_ZERO;
      end else if (sample_value < b1) begin
         item.kind = KIND_RATIO;
      end else if (sample_value < b2) begin
         item.kind = KIND_ONE;
      end else if ((b3 != b2) && (sample_value < b3)) begin
         item.kind = KIND_RATIO;
         num_hi = b3;
         num_lo = sample_value;
         den_hi = b3;
         den_lo = b2;
      end
      num_wide = 33'(num_hi) - 33'(num_lo);
      den_wide = 33'(den_hi) - 33'(den_lo);
      // both spans are non-negative and below 2^32 on the ratio paths
      item.num = num_wide[OPER_W-1:0];
      item.den = den_wide[OPER_W-1:0];
   end

   assign in_ready  = !front_vld_ff || !queue_full;
   assign in_fire   = in_valid && in_ready;
   assign push_fire = front_vld_ff && !queue_full;

   always_comb begin
      front_vld_in = front_vld_ff;
      if (in_fire) begin
         front_vld_in = 1'b1;
      end else if (push_fire) begin
         front_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         front_item_ff <= item;
      end
   end

   assign push_valid = front_vld_ff;
   assign push_item  = front_item_ff;

endmodule

// ===== hw/rtl/tm_queue.sv =====
module tm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  tm_pkg::grade_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output tm_pkg::grade_item_type head_item
);
   import tm_pkg::*;

   grade_item_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               push;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign push  = push_valid && !full;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/tm_back.sv =====
module tm_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  tm_pkg::grade_item_type head_item,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [FRAC_BITS:0]     membership
);
   import tm_pkg::*;

   localparam int STAGES = FRAC_BITS + 1;

   logic                     advance;
   logic [STAGES-1:0]        st_vld_ff;
   kind_type                 st_kind_ff [STAGES];
   logic [OPER_W-1:0]        st_rem_ff  [STAGES];
   logic [OPER_W-1:0]        st_den_ff  [STAGES];
   logic [FRAC_BITS:0]       st_quo_ff  [STAGES];
   logic                     out_vld_ff;
   logic [FRAC_BITS:0]       out_data_ff, out_data_in;

   // one stall for the whole pipe: move only when the output slot frees
   assign advance = !out_vld_ff || out_ready;
   assign pop     = advance && !queue_empty;

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic              src_vld;
      kind_type          src_kind;
      logic [OPER_W:0]   trial;
      logic [OPER_W:0]   trial_diff;
      logic [OPER_W-1:0] src_den;
      logic [FRAC_BITS:0] quo_in;
      logic              bit_set;

      if (k == 0) begin : g_first
         always_comb begin
            src_vld  = pop;
            src_kind = head_item.kind;
            trial    = {1'b0, head_item.num};
            src_den  = head_item.den;
         end
      end else begin : g_next
         always_comb begin
            src_vld  = st_vld_ff[k-1];
            src_kind = st_kind_ff[k-1];
            trial    = {st_rem_ff[k-1], 1'b0};
            src_den  = st_den_ff[k-1];
         end
      end

      always_comb begin
         trial_diff = trial - {1'b0, src_den};
         bit_set    = (trial >= {1'b0, src_den});
      end

      if (k == 0) begin : g_quo_first
         assign quo_in = {{FRAC_BITS{1'b0}}, bit_set};
      end else begin : g_quo_next
         assign quo_in = {st_quo_ff[k-1][FRAC_BITS-1:0], bit_set};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[k] <= 1'b0;
         end else if (advance) begin
            st_vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            st_kind_ff[k] <= src_kind;
            st_den_ff[k]  <= src_den;
            st_quo_ff[k]  <= quo_in;
            st_rem_ff[k]  <= bit_set ? trial_diff[OPER_W-1:0] : trial[OPER_W-1:0];
         end
      end
   end

   always_comb begin
      case (st_kind_ff[STAGES-1])
         KIND_RATIO: out_data_in = st_quo_ff[STAGES-1];
         KIND_ONE:   out_data_in = {1'b1, {FRAC_BITS{1'b0}}};
         default:    out_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= st_vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid  = out_vld_ff;
   assign membership = out_data_ff;

endmodule

// ===== hw/rtl/trapezoid_membership.sv =====
// Path: front reg, queue, one divider stage per quotient bit, output reg.
// Throughput: one beat per cycle unless rsp_tready stalls the output.
// A four-entry queue between the classifier and the divider absorbs stalls.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
`include "trapezoid_membership_assert.svh"

module trapezoid_membership #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_value, rise_start, rise_end, fall_start, fall_end (low bits first)
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // membership, zero-padded to whole bytes
   output logic [((FRAC_BITS+8)/8)*8-1:0] rsp_tdata
);
   import tm_pkg::*;

   localparam int DATA_W = ((FRAC_BITS + 8) / 8) * 8;

   logic               push_valid, queue_full, queue_empty, pop;
   grade_item_type     push_item, head_item;
   logic [FRAC_BITS:0] membership;

   tm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .sample_value (req_tdata[31:0]),
      .rise_start   (req_tdata[63:32]),
      .rise_end     (req_tdata[95:64]),
      .fall_start   (req_tdata[127:96]),
      .fall_end     (req_tdata[159:128]),
      .push_valid   (push_valid),
      .queue_full   (queue_full),
      .push_item    (push_item)
   );

   tm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_item  (head_item)
   );

   tm_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_item   (head_item),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .membership  (membership)
   );

   assign rsp_tdata = DATA_W'(membership);

   `TM_ASSERT_SAME(a_grade_range, clock, reset, rsp_tvalid, (membership <= {1'b1, {FRAC_BITS{1'b0}}}), "membership above one")
   `TM_ASSERT_NEXT(a_front_holds, clock, reset, req_tvalid && req_tready, push_valid, "accepted beat not staged")
   `TM_ASSERT_SAME(a_no_underflow, clock, reset, pop, !queue_empty, "pop from empty queue")

endmodule
